/* rtl/clock_sweep_buffer_replacer_macros.svh */
// assertion macros for the clock sweep buffer replacer
// used by rtl/clock_sweep_buffer_replacer.sv; expects i_clk and i_rst_n in scope
`ifndef CLOCK_SWEEP_BUFFER_REPLACER_MACROS_SVH
`define CLOCK_SWEEP_BUFFER_REPLACER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CSBR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold outside reset
`define CSBR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/csbr_pkg.sv */
// shared types and codes for the clock sweep buffer replacer
// no dependencies
package csbr_pkg;

    localparam int PAGE_W  = 32;
    localparam int USAGE_W = 3;

    // operation kinds
    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_PIN   = 2'd1;
    localparam logic [1:0] KIND_UNPIN = 2'd2;

    // result status codes
    localparam logic [2:0] ST_HIT          = 3'd0;
    localparam logic [2:0] ST_LOAD_EMPTY   = 3'd1;
    localparam logic [2:0] ST_LOAD_EVICT   = 3'd2;
    localparam logic [2:0] ST_ALL_PINNED   = 3'd3;
    localparam logic [2:0] ST_PIN_DONE     = 3'd4;
    localparam logic [2:0] ST_NOT_RESIDENT = 3'd5;

    // commands to a frame cell
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_SETU  = 3'd1;
    localparam logic [2:0] OP_PIN   = 3'd2;
    localparam logic [2:0] OP_UNPIN = 3'd3;
    localparam logic [2:0] OP_DEC   = 3'd4;
    localparam logic [2:0] OP_LOAD  = 3'd5;

    localparam logic [USAGE_W-1:0] RESET_MAX_USAGE = 3'd5;

    typedef struct packed {
        logic [2:0]         op;
        logic [USAGE_W-1:0] usage;
        logic [PAGE_W-1:0]  page;
    } t_cmd;

    typedef struct packed {
        logic               valid;
        logic               pinned;
        logic [USAGE_W-1:0] usage;
        logic [PAGE_W-1:0]  page;
    } t_frame;

endpackage

/* rtl/clock_sweep_buffer_replacer.sv */
// top level: frame cell chain plus lookup and sweep sequencer
// depends on csbr_pkg, csbr_cell and clock_sweep_buffer_replacer_macros.svh
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  command   | i_start / o_busy     | i_kind, i_page_id
//  result    | o_done (one cycle)   | o_status, o_frame_index, o_usage, o_evicted_page
//  config    | i_cfg_we             | i_cfg_wdata (max_usage)
//
// every command first runs the lookup chain: the match ripples through the
// registered cells, then the result is registered. a fetch miss with an
// unpinned frame then sweeps the clock hand one frame at a time, skipping pinned
// frames and aging the others, until it takes a frame whose usage is zero.
// reset is synchronous; no clearing pass. results cannot be stalled.
`include "clock_sweep_buffer_replacer_macros.svh"

module clock_sweep_buffer_replacer import csbr_pkg::*; #(
    parameter int NUM_FRAMES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_page_id,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [3:0]  o_frame_index,
    output logic [2:0]  o_usage,
    output logic [31:0] o_evicted_page
);

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = IW + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [IW-1:0]      r_hand, n_hand;
    logic [1:0]         r_kind;
    logic [PAGE_W-1:0]  r_key;
    logic [USAGE_W-1:0] r_max_usage;
    logic               r_done, n_done;
    logic [2:0]         r_status, n_status;
    logic [IW-1:0]      r_fidx, n_fidx;
    logic [USAGE_W-1:0] r_usage, n_usage;
    logic [PAGE_W-1:0]  r_evict, n_evict;

    t_cmd               w_cmd;
    logic [IW-1:0]      w_sel;
    logic               w_found  [NUM_FRAMES+1];
    logic [IW-1:0]      w_fi     [NUM_FRAMES+1];
    t_frame             w_frame  [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] w_unpinned;
    t_frame             w_hit_fr, w_hand_fr;
    logic [USAGE_W:0]   w_inc;
    logic               w_accept;
    logic               w_fail_status;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_found[0] = 1'b0;
    assign w_fi[0]    = '0;

    // row of frame cells
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        csbr_cell #(.IW(IW), .IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_sel       (w_sel),
            .i_key       (r_key),
            .i_found     (w_found[g]),
            .i_found_idx (w_fi[g]),
            .o_found     (w_found[g+1]),
            .o_found_idx (w_fi[g+1]),
            .o_frame     (w_frame[g])
        );
        assign w_unpinned[g] = !w_frame[g].pinned;
    end

    assign w_hit_fr  = w_frame[w_fi[NUM_FRAMES]];
    assign w_hand_fr = w_frame[r_hand];
    assign w_inc     = {1'b0, w_hit_fr.usage} + 4'd1;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_hand   = r_hand;
        n_done   = 1'b0;
        n_status = r_status;
        n_fidx   = r_fidx;
        n_usage  = r_usage;
        n_evict  = r_evict;
        w_cmd    = '{op: OP_NONE, usage: '0, page: r_key};
        w_sel    = w_fi[NUM_FRAMES];
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_FRAMES)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ST_NOT_RESIDENT;
                    n_fidx   = '0;
                    n_usage  = '0;
                    n_evict  = '0;
                    if (r_kind == KIND_FETCH) begin
                        if (w_found[NUM_FRAMES]) begin
                            n_status = ST_HIT;
                            n_fidx   = w_fi[NUM_FRAMES];
                            n_usage  = (w_inc > {1'b0, r_max_usage}) ? r_max_usage
                                                                     : w_inc[USAGE_W-1:0];
                            w_cmd.op    = OP_SETU;
                            w_cmd.usage = n_usage;
                        end else if (|w_unpinned) begin
                            n_state = S_SWEEP;
                            n_done  = 1'b0;
                        end else begin
                            n_status = ST_ALL_PINNED;
                        end
                    end else if ((r_kind == KIND_PIN || r_kind == KIND_UNPIN)
                                 && w_found[NUM_FRAMES]) begin
                        n_status = ST_PIN_DONE;
                        n_fidx   = w_fi[NUM_FRAMES];
                        n_usage  = w_hit_fr.usage;
                        w_cmd.op = (r_kind == KIND_PIN) ? OP_PIN : OP_UNPIN;
                    end
                end
            end
            S_SWEEP: begin
                w_sel  = r_hand;
                n_hand = (r_hand == IW'(NUM_FRAMES - 1)) ? '0 : r_hand + 1'b1;
                if (!w_hand_fr.pinned) begin
                    if (w_hand_fr.usage == '0) begin
                        w_cmd.op = OP_LOAD;
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = w_hand_fr.valid ? ST_LOAD_EVICT : ST_LOAD_EMPTY;
                        n_fidx   = r_hand;
                        n_usage  = 3'd1;
                        n_evict  = w_hand_fr.valid ? w_hand_fr.page : '0;
                    end else begin
                        w_cmd.op = OP_DEC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_hand      <= '0;
            r_done      <= 1'b0;
            r_max_usage <= RESET_MAX_USAGE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_hand  <= n_hand;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_max_usage <= i_cfg_wdata;
            end
        end
    end

    // command capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_key  <= i_page_id;
        end
        r_status <= n_status;
        r_fidx   <= n_fidx;
        r_usage  <= n_usage;
        r_evict  <= n_evict;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_frame_index  = 4'(r_fidx);
    assign o_usage        = r_usage;
    assign o_evicted_page = r_evict;

    // failure results carry no frame
    assign w_fail_status = (o_status == ST_ALL_PINNED) || (o_status == ST_NOT_RESIDENT);

    // checks
    `CSBR_ASSERT_IMP(a_done_idle, o_done, !o_busy, "result transfer while busy")
    `CSBR_ASSERT_IMP(a_done_after_work, o_done, $past(o_busy), "result without work")
    `CSBR_ASSERT_IMP(a_empty_idx, o_done && w_fail_status, o_frame_index == 4'd0 && o_usage == 3'd0, "nonzero fields on failure")
    `CSBR_ASSERT_NEVER(a_hand_range, r_hand > IW'(NUM_FRAMES - 1), "clock hand out of range")

endmodule

/* rtl/csbr_cell.sv */
// one frame cell: holds a frame's state and passes the lookup chain on
// depends on csbr_pkg
module csbr_cell import csbr_pkg::*; #(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_sel,
    input  logic [PAGE_W-1:0] i_key,
    input  logic          i_found,
    input  logic [IW-1:0] i_found_idx,
    output logic          o_found,
    output logic [IW-1:0] o_found_idx,
    output t_frame        o_frame
);

    logic               r_valid, r_pinned;
    logic [USAGE_W-1:0] r_usage;
    logic [PAGE_W-1:0]  r_page;
    logic               r_found;
    logic [IW-1:0]      r_found_idx;
    logic               w_me, w_match;

    assign w_me    = (i_sel == IW'(IDX));
    assign w_match = r_valid && (r_page == i_key);

    // frame state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_pinned <= 1'b0;
            r_usage  <= '0;
        end else if (w_me) begin
            case (i_cmd.op)
                OP_SETU:  r_usage  <= i_cmd.usage;
                OP_PIN:   r_pinned <= 1'b1;
                OP_UNPIN: r_pinned <= 1'b0;
                OP_DEC:   r_usage  <= r_usage - 3'd1;
                OP_LOAD: begin
                    r_valid  <= 1'b1;
                    r_pinned <= 1'b0;
                    r_usage  <= 3'd1;
                end
                default: ;
            endcase
        end
    end

    // page payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_me && i_cmd.op == OP_LOAD) begin
            r_page <= i_cmd.page;
        end
    end

    // lookup chain: first match from the low end wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= i_found || w_match;
        end
        r_found_idx <= i_found ? i_found_idx : IW'(IDX);
    end

    assign o_found     = r_found;
    assign o_found_idx = r_found_idx;
    assign o_frame     = '{valid: r_valid, pinned: r_pinned, usage: r_usage, page: r_page};

endmodule

/* sim/tb_clock_sweep_buffer_replacer.sv */
// testbench for the clock sweep buffer replacer: directed and random fetch/pin/unpin traffic
// checked against an in-bench frame table model; depends on csbr_pkg and the rtl top
`timescale 1ns / 1ps

module tb_clock_sweep_buffer_replacer;
    import csbr_pkg::*;

    localparam int NFRAMES  = 16;
    localparam int POOL_SZ  = 22;
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] page;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic [2:0]  usage;
        logic [31:0] evicted;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_page_id = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;
    logic        o_busy, o_done;
    logic [2:0]  o_status, o_usage;
    logic [3:0]  o_frame_index;
    logic [31:0] o_evicted_page;

    clock_sweep_buffer_replacer #(.NUM_FRAMES(NFRAMES)) u_top (.*);

    always #2 i_clk = ~i_clk;

    // frame table model
    logic [31:0] tbl_page   [NFRAMES];
    logic        tbl_valid  [NFRAMES];
    logic [2:0]  tbl_usage  [NFRAMES];
    logic        tbl_pinned [NFRAMES];
    logic [3:0]  hand;
    logic [2:0]  usage_cap;

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    int    err_cnt = 0;
    int    done_cnt = 0;
    int    gap_cnt = 0;
    bit    quiet = 0;
    logic [31:0] page_pool[POOL_SZ];
    int    hist[6];

    // update the table for one accepted transfer and queue the response
    function automatic void predict_access(logic [1:0] kind, logic [31:0] page);
        t_resp r;
        int hit;
        int victim;
        int steps;
        bit any_free;
        logic [3:0] h;
        r = '{ST_NOT_RESIDENT, 4'd0, 3'd0, 32'd0};
        hit = -1;
        victim = -1;
        any_free = 0;
        if (kind != KIND_BAD) begin
            for (int i = NFRAMES - 1; i >= 0; i--)
                if (tbl_valid[i] && tbl_page[i] == page) hit = i;
            if (kind == KIND_FETCH && hit >= 0) begin
                tbl_usage[hit] = (tbl_usage[hit] >= usage_cap) ? usage_cap
                                                               : tbl_usage[hit] + 3'd1;
                r = '{ST_HIT, 4'(hit), tbl_usage[hit], 32'd0};
            end else if (kind == KIND_FETCH) begin
                for (int i = 0; i < NFRAMES; i++)
                    if (!tbl_pinned[i]) any_free = 1;
                if (!any_free) begin
                    r.status = ST_ALL_PINNED;
                end else begin
                    // sweep: skip pinned, age nonzero counts, take first zero
                    for (steps = 0; steps < 9 * NFRAMES && victim < 0; steps++) begin
                        h = hand;
                        hand = hand + 4'd1;
                        if (!tbl_pinned[h]) begin
                            if (tbl_usage[h] == 0) victim = h;
                            else tbl_usage[h] = tbl_usage[h] - 3'd1;
                        end
                    end
                    r = '{tbl_valid[victim] ? ST_LOAD_EVICT : ST_LOAD_EMPTY, 4'(victim),
                          3'd1, tbl_valid[victim] ? tbl_page[victim] : 32'd0};
                    tbl_page[victim]   = page;
                    tbl_valid[victim]  = 1'b1;
                    tbl_usage[victim]  = 3'd1;
                    tbl_pinned[victim] = 1'b0;
                end
            end else if (hit >= 0) begin
                tbl_pinned[hit] = (kind == KIND_PIN);
                r = '{ST_PIN_DONE, 4'(hit), tbl_usage[hit], 32'd0};
            end
        end
        expected_resps.push_back(r);
    endfunction

    // driver: one item per transfer, random idle bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && o_busy) begin
                // hold current item
            end else if (gap_cnt > 0) begin
                i_start <= 1'b0;
                gap_cnt <= gap_cnt - 1;
            end else if (pending_reqs.size() > 0) begin
                i_kind    <= pending_reqs[0].kind;
                i_page_id <= pending_reqs[0].page;
                void'(pending_reqs.pop_front());
                i_start   <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) gap_cnt <= $urandom_range(1, 7);
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted transfer, check each done strobe
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n) begin
            if (i_start && !o_busy) predict_access(i_kind, i_page_id);
            if (o_done) begin
                done_cnt++;
                if (expected_resps.size() == 0) begin
                    $display("%0t: unexpected result status %0d", $time, o_status);
                    err_cnt++;
                end else begin
                    e = expected_resps.pop_front();
                    if (o_status <= 3'd5) hist[o_status]++;
                    if (o_status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                        err_cnt++;
                    end
                    if (o_frame_index !== e.frame) begin
                        $display("%0t: frame exp %0d got %0d", $time, e.frame, o_frame_index);
                        err_cnt++;
                    end
                    if (o_usage !== e.usage) begin
                        $display("%0t: usage exp %0d got %0d", $time, e.usage, o_usage);
                        err_cnt++;
                    end
                    if (o_evicted_page !== e.evicted) begin
                        $display("%0t: evicted exp %h got %h", $time, e.evicted,
                                 o_evicted_page);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic push_req(logic [1:0] kind, logic [31:0] page);
        pending_reqs.push_back('{kind, page});
    endtask

    // sample on the falling edge so driver updates have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_reqs.size() > 0 || expected_resps.size() > 0 || i_start || o_busy)
            @(negedge i_clk);
    endtask

    task automatic write_cap(logic [2:0] val);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        usage_cap = val;
    endtask

    // random phase: mostly fetches over a small page pool, plus pins, unpins and noise
    task automatic random_phase(int n);
        int sel;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0)
                page_pool[$urandom_range(0, POOL_SZ - 1)] = $urandom;
            sel = $urandom_range(0, 99);
            if (sel < 58)      push_req(KIND_FETCH, page_pool[$urandom_range(0, POOL_SZ - 1)]);
            else if (sel < 63) push_req(KIND_FETCH, $urandom);
            else if (sel < 78) push_req(KIND_PIN, page_pool[$urandom_range(0, POOL_SZ - 1)]);
            else if (sel < 95) push_req(KIND_UNPIN, page_pool[$urandom_range(0, POOL_SZ - 1)]);
            else               push_req(KIND_BAD, $urandom);
        end
    endtask

    // stimulus
    initial begin
        logic [2:0] caps[6] = '{3'd7, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5};
        for (int i = 0; i < NFRAMES; i++) begin
            tbl_page[i] = '0; tbl_valid[i] = 0; tbl_usage[i] = '0; tbl_pinned[i] = 0;
        end
        hand = '0;
        usage_cap = RESET_MAX_USAGE;
        foreach (hist[i]) hist[i] = 0;
        foreach (page_pool[i]) page_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, saturation, not resident, unused kind, all pinned
        push_req(KIND_PIN, 32'h0);
        push_req(KIND_BAD, 32'hFFFF_FFFF);
        for (int i = 0; i < NFRAMES; i++)
            push_req(KIND_FETCH, (i == 1) ? 32'hFFFF_FFFF : 32'(i * 32'h1111_1111));
        repeat (6) push_req(KIND_FETCH, 32'h0);
        for (int i = 0; i < NFRAMES; i++)
            push_req(KIND_PIN, (i == 1) ? 32'hFFFF_FFFF : 32'(i * 32'h1111_1111));
        push_req(KIND_FETCH, 32'hDEAD_BEEF);
        push_req(KIND_UNPIN, 32'h0);
        push_req(KIND_FETCH, 32'hDEAD_BEEF);
        for (int i = 1; i < NFRAMES; i++)
            push_req(KIND_UNPIN, (i == 1) ? 32'hFFFF_FFFF : 32'(i * 32'h1111_1111));

        foreach (caps[p]) begin
            write_cap(caps[p]);
            if (p == 5) quiet = 1;
            random_phase(180);
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("covered %0d results: hit %0d, load empty %0d, evict %0d", done_cnt,
                 hist[0], hist[1], hist[2]);
        $display("all pinned %0d, pin/unpin %0d, not resident %0d over 7 limit settings",
                 hist[3], hist[4], hist[5]);
        if (err_cnt == 0 && expected_resps.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
